// ===== design/vocf_pkg.sv =====
// Package for the vertex order conflict flagger.
// Holds item widths, mode codes, the controller state type and default sizes.
// No dependencies.
package vocf_pkg;

  localparam int VERTEX_COUNT_DEF = 256;

  localparam int VERTEX_W = 8;
  localparam int MODE_W   = 2;
  localparam int TOTAL_W  = 9;

  // Slave tuser: mode, vertex_present. Master tdata: conflict, vertex_flagged, flagged_total.
  localparam int S_TUSER_W = MODE_W + 1;
  localparam int M_TDATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_VISIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAIR,
    ST_FLAG_A,
    ST_FLAG_B,
    ST_QUERY
  } state_e;

endpackage

// ===== design/vertex_order_conflict_flagger.sv =====
// Top level of the vertex order conflict flagger.
// Holds the pair bitmap and vertex flag bitmap memories and their controller.
// Depends on vocf_pkg.
//
// Usage: items enter on the s_axis group and one result per item leaves on the
// m_axis group. A visit records the pair (previous vertex, vertex) in a pair
// bitmap memory; if the mirror pair was already there, both vertices are set in
// a flag memory and the flagged total grows for each newly flagged vertex.
// A boundary item ends the read, a query item returns one vertex's flag.
// Reset: a clearing pass writes zero to every pair entry, one entry a cycle;
// the flag memory is cleared during the same pass. s_axis_tready stays low
// meanwhile. Per item: a boundary, unused mode, out-of-range query or a visit
// forming no pair puts its result straight into the output register; a query
// first reads the flag memory; a pair reads the pair memory, then writes the
// new pair; a conflict then adds two read-modify-writes on the flag memory.
// One item is in work at a time, so a new item waits until the last is done.
// The result sits in an output register; while the receiver stalls it holds,
// and a new item is taken as soon as that register is free or being emptied in
// the same cycle.
module vertex_order_conflict_flagger #(
  parameter int VERTEX_COUNT = vocf_pkg::VERTEX_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [vocf_pkg::VERTEX_W-1:0]    s_axis_tdata,  // [7:0] vertex
  input  logic [vocf_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // [1:0] mode, [2] vertex_present
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] conflict, [1] vertex_flagged, [10:2] flagged_total, [15:11] zero
  output logic [vocf_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int IdxW  = (VERTEX_COUNT > 2) ? $clog2(VERTEX_COUNT) : 1;
  localparam int CmpW  = ((IdxW > vocf_pkg::VERTEX_W) ? IdxW : vocf_pkg::VERTEX_W) + 1;
  localparam int PairW = 2 * IdxW;
  localparam int PairDepth = 1 << PairW;
  localparam int FlagDepth = 1 << IdxW;
  localparam int TW = vocf_pkg::TOTAL_W;

  vocf_pkg::state_e state_q, state_d;

  logic [PairW-1:0] clr_q, clr_d;
  logic [IdxW-1:0]  prev_q, prev_d;
  logic             prev_vld_q, prev_vld_d;
  logic [TW-1:0]    count_q, count_d;
  logic [IdxW-1:0]  from_q, from_d;
  logic [IdxW-1:0]  vidx_q, vidx_d;
  logic             out_vld_q, out_vld_d;
  logic             out_conf_q, out_conf_d;
  logic             out_flag_q, out_flag_d;

  // memories
  logic             pair_mem [PairDepth];
  logic             pair_rd_q;
  logic             pair_re, pair_we, pair_wdata;
  logic [PairW-1:0] pair_raddr, pair_waddr;

  logic             flag_mem [FlagDepth];
  logic             flag_rd_q;
  logic             flag_re, flag_we, flag_wdata;
  logic [IdxW-1:0]  flag_raddr, flag_waddr;

  // input decode
  logic [vocf_pkg::MODE_W-1:0] mode;
  logic [CmpW-1:0]             vert_ext;
  logic [IdxW-1:0]             vidx;
  logic                        in_range, present, accept, slot_free, forms_pair;
  logic [TW-1:0]               count_inc;

  assign mode       = s_axis_tuser[vocf_pkg::MODE_W-1:0];
  assign present    = s_axis_tuser[vocf_pkg::MODE_W];
  assign vert_ext   = CmpW'(s_axis_tdata);
  assign vidx       = vert_ext[IdxW-1:0];
  assign in_range   = vert_ext < CmpW'(VERTEX_COUNT);
  assign forms_pair = prev_vld_q && (prev_q != vidx);
  assign slot_free  = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == vocf_pkg::ST_IDLE) && slot_free;
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign count_inc  = (count_q == {TW{1'b1}}) ? count_q : count_q + TW'(1);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(vocf_pkg::M_TDATA_W - TW - 2)'(0), count_q, out_flag_q, out_conf_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vocf_pkg::ST_CLEAR: begin
        if (clr_q == {PairW{1'b1}}) state_d = vocf_pkg::ST_IDLE;
      end
      vocf_pkg::ST_IDLE: begin
        if (accept) begin
          if (mode == vocf_pkg::MODE_VISIT && present && in_range && forms_pair) begin
            state_d = vocf_pkg::ST_PAIR;
          end else if (mode == vocf_pkg::MODE_QUERY && in_range) begin
            state_d = vocf_pkg::ST_QUERY;
          end
        end
      end
      vocf_pkg::ST_PAIR: begin
        state_d = pair_rd_q ? vocf_pkg::ST_FLAG_A : vocf_pkg::ST_IDLE;
      end
      vocf_pkg::ST_FLAG_A: state_d = vocf_pkg::ST_FLAG_B;
      vocf_pkg::ST_FLAG_B: state_d = vocf_pkg::ST_IDLE;
      vocf_pkg::ST_QUERY:  state_d = vocf_pkg::ST_IDLE;
      default:             state_d = vocf_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_d      = clr_q;
    prev_d     = prev_q;
    prev_vld_d = prev_vld_q;
    count_d    = count_q;
    from_d     = from_q;
    vidx_d     = vidx_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_conf_d = out_conf_q;
    out_flag_d = out_flag_q;
    pair_re    = 1'b0;
    pair_raddr = {vidx, prev_q};
    pair_we    = 1'b0;
    pair_waddr = {from_q, vidx_q};
    pair_wdata = 1'b1;
    flag_re    = 1'b0;
    flag_raddr = from_q;
    flag_we    = 1'b0;
    flag_waddr = from_q;
    flag_wdata = 1'b1;
    case (state_q)
      vocf_pkg::ST_CLEAR: begin
        pair_we    = 1'b1;
        pair_waddr = clr_q;
        pair_wdata = 1'b0;
        flag_we    = 1'b1;
        flag_waddr = clr_q[IdxW-1:0];
        flag_wdata = 1'b0;
        clr_d      = clr_q + PairW'(1);
      end
      vocf_pkg::ST_IDLE: begin
        if (accept) begin
          from_d = prev_q;
          vidx_d = vidx;
          out_conf_d = 1'b0;
          out_flag_d = 1'b0;
          if (mode == vocf_pkg::MODE_VISIT) begin
            if (present && in_range) begin
              prev_d     = vidx;
              prev_vld_d = 1'b1;
              if (forms_pair) begin
                // fetch the mirror pair (vertex, previous)
                pair_re = 1'b1;
              end else begin
                out_vld_d = 1'b1;
              end
            end else begin
              out_vld_d = 1'b1;
            end
          end else if (mode == vocf_pkg::MODE_END) begin
            prev_vld_d = 1'b0;
            out_vld_d  = 1'b1;
          end else if (mode == vocf_pkg::MODE_QUERY && in_range) begin
            flag_re    = 1'b1;
            flag_raddr = vidx;
          end else begin
            out_vld_d = 1'b1;
          end
        end
      end
      vocf_pkg::ST_PAIR: begin
        pair_we = 1'b1;
        if (pair_rd_q) begin
          flag_re = 1'b1;
        end else begin
          out_vld_d = 1'b1;
        end
      end
      vocf_pkg::ST_FLAG_A: begin
        if (!flag_rd_q) begin
          flag_we = 1'b1;
          count_d = count_inc;
        end
        flag_re    = 1'b1;
        flag_raddr = vidx_q;
      end
      vocf_pkg::ST_FLAG_B: begin
        if (!flag_rd_q) begin
          flag_we    = 1'b1;
          flag_waddr = vidx_q;
          count_d    = count_inc;
        end
        out_conf_d = 1'b1;
        out_vld_d  = 1'b1;
      end
      vocf_pkg::ST_QUERY: begin
        out_flag_d = flag_rd_q;
        out_vld_d  = 1'b1;
      end
      default: begin
        out_vld_d = out_vld_q && !m_axis_tready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= vocf_pkg::ST_CLEAR;
      clr_q      <= '0;
      prev_q     <= '0;
      prev_vld_q <= 1'b0;
      count_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      prev_q     <= prev_d;
      prev_vld_q <= prev_vld_d;
      count_q    <= count_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    from_q     <= from_d;
    vidx_q     <= vidx_d;
    out_conf_q <= out_conf_d;
    out_flag_q <= out_flag_d;
  end

  // pair bitmap: one write and one read port, registered read
  always_ff @(posedge clk_i) begin
    if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
    if (pair_re) pair_rd_q <= pair_mem[pair_raddr];
  end

  // vertex flag bitmap
  always_ff @(posedge clk_i) begin
    if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
    if (flag_re) flag_rd_q <= flag_mem[flag_raddr];
  end

endmodule

// ===== verif/tb_vertex_order_conflict_flagger.sv =====
// Testbench for the vertex order conflict flagger: directed reads, then random reads
// with mirrored orders, checked item by item against a bitmap-based predictor.
// Depends on vocf_pkg and vertex_order_conflict_flagger.
module tb_vertex_order_conflict_flagger;

  localparam int VERTEX_COUNT = vocf_pkg::VERTEX_COUNT_DEF;
  localparam int VERTEX_W     = vocf_pkg::VERTEX_W;
  localparam int MODE_W       = vocf_pkg::MODE_W;
  localparam int TOTAL_W      = vocf_pkg::TOTAL_W;
  localparam int S_TUSER_W    = vocf_pkg::S_TUSER_W;
  localparam int M_TDATA_W    = vocf_pkg::M_TDATA_W;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_TAIL   = 150;
  localparam int LONG_HOLD    = 200;
  // Nothing is accepted during the clearing pass after reset.
  localparam int IDLE_LIMIT   = 300000;

  typedef struct {
    bit                 conflict;
    bit                 flagged;
    logic [TOTAL_W-1:0] total;
  } answer_t;

  class vertex_order_tracker;
    bit                  pair_map [VERTEX_COUNT*VERTEX_COUNT];
    bit                  flag_map [VERTEX_COUNT];
    logic [VERTEX_W-1:0] last_vertex = '0;
    bit                  last_valid;
    logic [TOTAL_W-1:0]  flagged_count = '0;
    answer_t             awaited_answers[$];
    int                  bad_fields;

    function void mark_vertex(int v);
      if (!flag_map[v]) begin
        flag_map[v] = 1'b1;
        if (flagged_count != '1) flagged_count++;
      end
    endfunction

    function void take_item(logic [MODE_W-1:0] mode, logic [VERTEX_W-1:0] vertex,
                            bit present);
      answer_t a;
      int      v;
      int      u;
      a.conflict = 1'b0;
      a.flagged  = 1'b0;
      v = int'(vertex);
      u = int'(last_vertex);
      case (mode)
        vocf_pkg::MODE_VISIT: begin
          if (present && v < VERTEX_COUNT) begin
            if (last_valid && u != v) begin
              if (pair_map[v*VERTEX_COUNT + u]) begin
                a.conflict = 1'b1;
                mark_vertex(u);
                mark_vertex(v);
              end
              pair_map[u*VERTEX_COUNT + v] = 1'b1;
            end
            last_vertex = vertex;
            last_valid  = 1'b1;
          end
        end
        vocf_pkg::MODE_END: begin
          last_valid = 1'b0;
        end
        vocf_pkg::MODE_QUERY: begin
          a.flagged = (v < VERTEX_COUNT) && flag_map[v];
        end
        default: ;
      endcase
      a.total = flagged_count;
      awaited_answers = {awaited_answers, a};
    endfunction

    function void match_result(logic [M_TDATA_W-1:0] word);
      answer_t a;
      if (awaited_answers.size() == 0) begin
        bad_fields++;
        if (bad_fields <= 10) $display("result %h arrived with no item awaiting one", word);
        return;
      end
      a = awaited_answers.pop_front();
      if (word[0] !== a.conflict || word[1] !== a.flagged || word[10:2] !== a.total) begin
        bad_fields++;
        if (bad_fields <= 10)
          $display({"mismatch: conflict exp %0d got %0d, flagged exp %0d got %0d,",
                    " total exp %0d got %0d"},
                   a.conflict, word[0], a.flagged, word[1], a.total, word[10:2]);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [VERTEX_W-1:0]  s_axis_tdata;   // [7:0] vertex
  logic [S_TUSER_W-1:0] s_axis_tuser;   // [1:0] mode, [2] vertex_present
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // [0] conflict, [1] vertex_flagged, [10:2] total

  vertex_order_tracker tracker = new();

  int                  items_sent;
  int                  idle_cycles;
  bit                  tx_gaps_on;
  bit                  rx_stalls_on;
  bit                  long_hold_req;
  logic [VERTEX_W-1:0] pool_base;
  logic [VERTEX_W-1:0] prior_read[$];

  vertex_order_conflict_flagger #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Note accepted items, check accepted results, and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) tracker.match_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_item(s_axis_tuser[MODE_W-1:0], s_axis_tdata, s_axis_tuser[MODE_W]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random stall bursts, and one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [VERTEX_W-1:0] vertex,
                           input bit present);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= vertex;
    s_axis_tuser  <= {present, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic wait_for_answers();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.awaited_answers.size() != 0) @(posedge clk_i);
  endtask

  // Mostly a small pool, so that pairs and their mirrors meet.
  function automatic logic [VERTEX_W-1:0] pick_vertex();
    if ($urandom_range(0, 4) == 0) return VERTEX_W'($urandom);
    return pool_base + VERTEX_W'($urandom_range(0, 15));
  endfunction

  task automatic random_read();
    logic [VERTEX_W-1:0] path[$];
    int                  len;
    if (prior_read.size() > 1 && $urandom_range(0, 2) == 0) begin
      // walk the previous read backwards to provoke conflicts
      for (int i = prior_read.size() - 1; i >= 0; i--) path = {path, prior_read[i]};
    end else begin
      len = $urandom_range(2, 8);
      repeat (len) path = {path, pick_vertex()};
    end
    foreach (path[i]) begin
      if ($urandom_range(0, 9) == 0)
        send_item(vocf_pkg::MODE_VISIT, VERTEX_W'($urandom), 1'b0);
      if ($urandom_range(0, 19) == 0)
        send_item(vocf_pkg::MODE_QUERY, pick_vertex(), 1'($urandom));
      if ($urandom_range(0, 29) == 0)
        send_item(MODE_UNUSED, VERTEX_W'($urandom), 1'($urandom));
      send_item(vocf_pkg::MODE_VISIT, path[i], 1'b1);
      if ($urandom_range(0, 19) == 0) send_item(vocf_pkg::MODE_VISIT, path[i], 1'b1);
    end
    send_item(vocf_pkg::MODE_END, VERTEX_W'($urandom), 1'($urandom));
    if ($urandom_range(0, 2) == 0)
      send_item(vocf_pkg::MODE_QUERY, path[$urandom_range(0, path.size() - 1)],
                1'($urandom));
    prior_read = path;
  endtask

  initial begin
    int  random_start;
    int  next_shuffle;
    bit  held;
    bit  paused;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    tx_gaps_on    = 1'b0;
    rx_stalls_on  = 1'b0;
    long_hold_req = 1'b0;
    pool_base     = '0;
    items_sent    = 0;
    idle_cycles   = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // First visit, repeated vertex, absent visit, then a pair.
    send_item(vocf_pkg::MODE_VISIT, 8'd0, 1'b1);
    send_item(vocf_pkg::MODE_VISIT, 8'd0, 1'b1);
    send_item(vocf_pkg::MODE_VISIT, 8'd255, 1'b0);
    send_item(vocf_pkg::MODE_VISIT, 8'd255, 1'b1);
    send_item(vocf_pkg::MODE_END, 8'd0, 1'b0);
    // Mirror pair, then the same pair again across a skipped visit.
    send_item(vocf_pkg::MODE_VISIT, 8'd255, 1'b1);
    send_item(vocf_pkg::MODE_VISIT, 8'd0, 1'b1);
    send_item(vocf_pkg::MODE_VISIT, 8'd0, 1'b0);
    send_item(vocf_pkg::MODE_VISIT, 8'd255, 1'b1);
    send_item(vocf_pkg::MODE_END, 8'd0, 1'b0);
    send_item(vocf_pkg::MODE_QUERY, 8'd0, 1'b1);
    send_item(vocf_pkg::MODE_QUERY, 8'd255, 1'b1);
    send_item(vocf_pkg::MODE_QUERY, 8'd128, 1'b1);
    send_item(MODE_UNUSED, 8'd170, 1'b1);
    send_item(MODE_UNUSED, 8'd85, 1'b0);
    // Vertices either side of a skip still form a pair.
    send_item(vocf_pkg::MODE_VISIT, 8'd1, 1'b1);
    send_item(vocf_pkg::MODE_VISIT, 8'd200, 1'b0);
    send_item(vocf_pkg::MODE_VISIT, 8'd2, 1'b1);
    send_item(vocf_pkg::MODE_END, 8'd0, 1'b0);
    send_item(vocf_pkg::MODE_VISIT, 8'd2, 1'b1);
    send_item(vocf_pkg::MODE_VISIT, 8'd1, 1'b1);
    send_item(vocf_pkg::MODE_END, 8'd255, 1'b1);
    send_item(vocf_pkg::MODE_QUERY, 8'd1, 1'b0);

    random_start = items_sent;
    next_shuffle = items_sent;
    held         = 1'b0;
    paused       = 1'b0;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      if (items_sent >= next_shuffle) begin
        pool_base    = VERTEX_W'($urandom);
        tx_gaps_on   = $urandom_range(0, 2) != 0;
        rx_stalls_on = $urandom_range(0, 2) != 0;
        next_shuffle += 100;
      end
      if (!held && items_sent >= random_start + 300) begin
        // hold the receiver off while items keep coming, so the input stalls
        long_hold_req = 1'b1;
        held          = 1'b1;
      end
      if (!paused && items_sent >= random_start + 600) begin
        wait_for_answers();
        paused = 1'b1;
      end
      if (items_sent >= random_start + RANDOM_ITEMS - QUIET_TAIL) begin
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
      end
      if ($urandom_range(0, 4) == 0)
        send_item(MODE_W'($urandom_range(0, 3)), VERTEX_W'($urandom), 1'($urandom));
      else
        random_read();
    end

    wait_for_answers();
    repeat (8) @(posedge clk_i);
    if (tracker.bad_fields == 0 && tracker.awaited_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
